### hdl/segx_pkg.sv
// Package for segment_intersection: widths, transaction types and status codes.
// No dependencies.
package segx_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_SINGLE  = 2'd1;
  localparam logic [1:0] ST_OVERLAP = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FRAC_BITS:0] time_a;
    logic [FRAC_BITS:0] time_b;
  } seg_out_t;
endpackage

### hdl/segx_div.sv
// Pipelined restoring fraction divider: floor(num * 2^FRAC_BITS / den), num < den.
// One quotient bit per stage; sat_i forces 2^FRAC_BITS; all stages move on en_i.
module segx_div #(
  parameter int NW = 34,
  parameter int FRAC_BITS = 16,
  parameter int TW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [NW-1:0]        num_i,
  input  logic [NW-1:0]        den_i,
  input  logic                 sat_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 vld_o,
  output logic [FRAC_BITS:0]   q_o,
  output logic [TW-1:0]        tag_o
);
  logic [FRAC_BITS:0]             v_q;
  logic [FRAC_BITS:0][NW:0]       r_q;
  logic [FRAC_BITS:0][NW-1:0]     d_q;
  logic [FRAC_BITS:0][FRAC_BITS:0] qq_q;
  logic [FRAC_BITS:0]             s_q;
  logic [FRAC_BITS:0][TW-1:0]     t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[FRAC_BITS-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]  <= {1'b0, num_i};
      d_q[0]  <= den_i;
      qq_q[0] <= '0;
      s_q[0]  <= sat_i;
      t_q[0]  <= tag_i;
      for (int k = 1; k <= FRAC_BITS; k++) begin
        logic [NW+1:0] sh;
        sh = {r_q[k-1], 1'b0};
        d_q[k]  <= d_q[k-1];
        s_q[k]  <= s_q[k-1];
        t_q[k]  <= t_q[k-1];
        if (sh >= {2'b00, d_q[k-1]}) begin
          r_q[k]  <= (NW+1)'(sh - {2'b00, d_q[k-1]});
          qq_q[k] <= {qq_q[k-1][FRAC_BITS-1:0], 1'b1};
        end else begin
          r_q[k]  <= sh[NW:0];
          qq_q[k] <= {qq_q[k-1][FRAC_BITS-1:0], 1'b0};
        end
      end
    end
  end

  assign vld_o = v_q[FRAC_BITS];
  assign tag_o = t_q[FRAC_BITS];
  assign q_o   = s_q[FRAC_BITS] ? (FRAC_BITS+1)'(1) << FRAC_BITS : qq_q[FRAC_BITS];
endmodule

### hdl/segx_geom.sv
// Front end: differences, cross products, collinear tests and classification.
// Three register stages; uses segx_pkg widths, types and codes.
module segx_geom
  import segx_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  seg_in_t                   crd_i,
  output logic                      vld_o,
  output logic [2*COORD_BITS+1:0]   na_o,
  output logic [2*COORD_BITS+1:0]   nb_o,
  output logic [2*COORD_BITS+1:0]   cp_o,
  output logic                      sa_o,
  output logic                      sb_o,
  output logic [1:0]                st_o,
  output logic                      fixed_o,
  output logic [FRAC_BITS:0]        ta_o,
  output logic [FRAC_BITS:0]        tb_o
);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2*COORD_BITS + 2;
  localparam int CW = 2*COORD_BITS + 3;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic signed [COORD_BITS-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  assign {asx, asy, aex, aey, bsx, bsy, bex, bey} = crd_i;

  // stage 1: differences and equality/box flags
  logic v1_q;
  logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q, ox_q, oy_q;
  logic signed [DW-1:0] ebx_q, eby_q, fax_q, fay_q, gax_q, gay_q;
  logic bseas_q, bseae_q, beeae_q, beeas_q;
  logic [3:0] box_q;

  function automatic logic inb(logic signed [COORD_BITS-1:0] v, p, q);
    return (p < q) ? (v >= p && v <= q) : (v >= q && v <= p);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= vld_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dax_q <= DW'(aex) - DW'(asx);  day_q <= DW'(aey) - DW'(asy);
      dbx_q <= DW'(bex) - DW'(bsx);  dby_q <= DW'(bey) - DW'(bsy);
      ox_q  <= DW'(bsx) - DW'(asx);  oy_q  <= DW'(bsy) - DW'(asy);
      ebx_q <= DW'(bex) - DW'(asx);  eby_q <= DW'(bey) - DW'(asy);
      fax_q <= DW'(asx) - DW'(bsx);  fay_q <= DW'(asy) - DW'(bsy);
      gax_q <= DW'(aex) - DW'(bsx);  gay_q <= DW'(aey) - DW'(bsy);
      bseas_q <= (bsx == asx) && (bsy == asy);
      bseae_q <= (bsx == aex) && (bsy == aey);
      beeae_q <= (bex == aex) && (bey == aey);
      beeas_q <= (bex == asx) && (bey == asy);
      box_q <= {inb(aex, bsx, bex) && inb(aey, bsy, bey),
                inb(asx, bsx, bex) && inb(asy, bsy, bey),
                inb(bex, asx, aex) && inb(bey, asy, aey),
                inb(bsx, asx, aex) && inb(bsy, asy, aey)};
    end
  end

  // stage 2: products
  logic v2_q;
  logic signed [PW-1:0] p_q [14];
  logic [3:0] box2_q;
  logic bseas2_q, bseae2_q, beeae2_q, beeas2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]  <= PW'(dax_q * dby_q);  p_q[1]  <= PW'(day_q * dbx_q);
      p_q[2]  <= PW'(ox_q * dby_q);   p_q[3]  <= PW'(oy_q * dbx_q);
      p_q[4]  <= PW'(ox_q * day_q);   p_q[5]  <= PW'(oy_q * dax_q);
      p_q[6]  <= PW'(dax_q * dbx_q);  p_q[7]  <= PW'(day_q * dby_q);
      p_q[8]  <= PW'(ebx_q * day_q);  p_q[9]  <= PW'(eby_q * dax_q);
      p_q[10] <= PW'(fax_q * dby_q);  p_q[11] <= PW'(fay_q * dbx_q);
      p_q[12] <= PW'(gax_q * dby_q);  p_q[13] <= PW'(gay_q * dbx_q);
      box2_q <= box_q;
      bseas2_q <= bseas_q; bseae2_q <= bseae_q;
      beeae2_q <= beeae_q; beeas2_q <= beeas_q;
    end
  end

  // stage 3: differences of products, sign fold, classify
  logic signed [CW-1:0] cp, na, nb, dt, ca, cb, cc, cd;
  logic signed [CW-1:0] acp, ana, anb;
  logic same, on_bs, on_be, on_as, on_ae, hit;
  always_comb begin
    cp = CW'(p_q[0]) - CW'(p_q[1]);
    na = CW'(p_q[2]) - CW'(p_q[3]);
    nb = CW'(p_q[4]) - CW'(p_q[5]);
    dt = CW'(p_q[6]) + CW'(p_q[7]);
    ca = CW'(p_q[4]) - CW'(p_q[5]);   // cross(bs-as, dA) ~ nb
    cb = CW'(p_q[8]) - CW'(p_q[9]);
    cc = CW'(p_q[10]) - CW'(p_q[11]);
    cd = CW'(p_q[12]) - CW'(p_q[13]);
    acp = cp[CW-1] ? -cp : cp;
    ana = cp[CW-1] ? -na : na;
    anb = cp[CW-1] ? -nb : nb;
    same  = dt > 0;
    on_bs = (ca == 0) && box2_q[0];
    on_be = (cb == 0) && box2_q[1];
    on_as = (cc == 0) && box2_q[2];
    on_ae = (cd == 0) && box2_q[3];
    hit = !ana[CW-1] && (ana <= acp) && !anb[CW-1] && (anb <= acp);
  end

  logic [1:0] st_d;
  logic [FRAC_BITS:0] ta_d, tb_d;
  logic fixed_d;
  always_comb begin
    st_d = ST_NONE;
    ta_d = '0;
    tb_d = '0;
    fixed_d = 1'b1;
    if (cp != 0) begin
      if (hit) begin
        st_d = ST_SINGLE;
        fixed_d = 1'b0;
      end
    end else if (on_bs) begin
      if (bseas2_q && !same) st_d = ST_SINGLE;
      else if (bseae2_q && same) begin st_d = ST_SINGLE; ta_d = ONE; end
      else st_d = ST_OVERLAP;
    end else if (on_be) begin
      if (beeae2_q && !same) begin st_d = ST_SINGLE; ta_d = ONE; tb_d = ONE; end
      else if (beeas2_q && same) begin st_d = ST_SINGLE; tb_d = ONE; end
      else st_d = ST_OVERLAP;
    end else if (on_as || on_ae) begin
      st_d = ST_OVERLAP;
    end
  end

  logic v3_q;
  logic [PW-1:0] na_q, nb_q, cp_q;
  logic sa_q, sb_q, fixed_q;
  logic [1:0] st_q;
  logic [FRAC_BITS:0] ta_q, tb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en_i) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q <= ana[PW-1:0];
      nb_q <= anb[PW-1:0];
      cp_q <= acp[PW-1:0];
      sa_q <= ana >= acp;
      sb_q <= anb >= acp;
      ta_q <= ta_d;
      tb_q <= tb_d;
      fixed_q <= fixed_d;
      st_q <= st_d;
    end
  end
  assign vld_o   = v3_q;
  assign na_o    = na_q;
  assign nb_o    = nb_q;
  assign cp_o    = cp_q;
  assign sa_o    = sa_q;
  assign sb_o    = sb_q;
  assign st_o    = st_q;
  assign fixed_o = fixed_q;
  assign ta_o    = ta_q;
  assign tb_o    = tb_q;
endmodule

### hdl/segment_intersection.sv
// Segment intersection: 3 geometry stages, then FRAC_BITS+1 divider stages for ta and tb.
// Throughput one transaction per cycle; a stall freezes the whole pipeline.
// Reset clears all valid bits; data registers are not reset; no clearing pass.
module segment_intersection
  import segx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  seg_in_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output seg_out_t out_data_o
);
  localparam int NW = 2*COORD_BITS + 2;
  localparam int TW = 2 + 2*(FRAC_BITS+1) + 1;

  // advance whenever the output slot is free or being taken
  logic en;
  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  logic g_vld, sa, sb, fixed;
  logic [NW-1:0] na, nb, cp;
  logic [1:0] st;
  logic [FRAC_BITS:0] ta, tb, qa, qb;
  logic va, vb;
  logic [TW-1:0] tag_a, tag_b;

  segx_geom u_geom (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .crd_i(in_data_i),
    .vld_o(g_vld), .na_o(na), .nb_o(nb), .cp_o(cp), .sa_o(sa), .sb_o(sb),
    .st_o(st), .fixed_o(fixed), .ta_o(ta), .tb_o(tb)
  );

  segx_div #(.NW(NW), .FRAC_BITS(FRAC_BITS), .TW(TW)) u_div_a (
    .clk_i, .rst_ni, .en_i(en), .vld_i(g_vld), .num_i(na), .den_i(cp), .sat_i(sa),
    .tag_i({st, ta, tb, fixed}), .vld_o(va), .q_o(qa), .tag_o(tag_a)
  );
  segx_div #(.NW(NW), .FRAC_BITS(FRAC_BITS), .TW(TW)) u_div_b (
    .clk_i, .rst_ni, .en_i(en), .vld_i(g_vld), .num_i(nb), .den_i(cp), .sat_i(sb),
    .tag_i({st, ta, tb, fixed}), .vld_o(vb), .q_o(qb), .tag_o(tag_b)
  );

  logic out_v_q;
  logic [2*FRAC_BITS+3:0] out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= va;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tag_a[0]) out_q <= tag_a[TW-1:1];
      else out_q <= {tag_a[TW-1:TW-2], qa, (vb && tag_b[0]) ? tag_b[FRAC_BITS+1:1] : qb};
    end
  end
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule

### hdl/segx_check.sv
// Port-level checker for segment_intersection, bound to the top level.
// Depends on segx_pkg types and status codes.
module segx_check
  import segx_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input logic     in_stall_o,
  input seg_out_t out_data_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o)) else $error("hold");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_OVERLAP) else $error("status");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_SINGLE
      |-> out_data_o.time_a == '0 && out_data_o.time_b == '0) else $error("times");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i) else $error("stall");
endmodule

bind segment_intersection segx_check u_segx_check (.*);

### tb/segment_intersection_tb.sv
// Testbench for segment_intersection: directed table plus random segment pairs, each
// checked against its typed table result or an in-bench predictor of the crossing
// status and parameters. Depends on segx_pkg and segment_intersection.
`timescale 1ns / 1ps

module segment_intersection_tb;
  import segx_pkg::*;

  localparam int N_RANDOM = 1600;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  typedef struct {
    seg_in_t  p;
    bit       typed;
    seg_out_t r;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  seg_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  seg_out_t out_data_o;

  seg_out_t hit_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  segment_intersection u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic bit on_segment(longint px, longint py, longint sx, longint sy,
                                    longint ex, longint ey);
    if (cross2(px - sx, py - sy, ex - sx, ey - sy) != 0) return 1'b0;
    return px >= ((sx < ex) ? sx : ex) && px <= ((sx < ex) ? ex : sx) &&
           py >= ((sy < ey) ? sy : ey) && py <= ((sy < ey) ? ey : sy);
  endfunction

  function automatic logic [FRAC_BITS:0] frac_q16(longint num, longint den);
    logic [FRAC_BITS:0] q;
    q = '0;
    if (num >= den) return T_ONE;
    for (int k = 0; k < FRAC_BITS; k++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic seg_out_t predict_hit(seg_in_t p);
    longint asx, asy, aex, aey, bsx, bsy, bex, bey;
    longint dax, day, dbx, dby, ox, oy, cp, na, nb;
    bit same;
    seg_out_t r;
    asx = p.a_start_x; asy = p.a_start_y; aex = p.a_end_x; aey = p.a_end_y;
    bsx = p.b_start_x; bsy = p.b_start_y; bex = p.b_end_x; bey = p.b_end_y;
    dax = aex - asx; day = aey - asy;
    dbx = bex - bsx; dby = bey - bsy;
    ox = bsx - asx; oy = bsy - asy;
    cp = cross2(dax, day, dbx, dby);
    r = '{ST_NONE, '0, '0};
    if (cp != 0) begin
      na = cross2(ox, oy, dbx, dby);
      nb = cross2(ox, oy, dax, day);
      if (cp < 0) begin
        cp = -cp; na = -na; nb = -nb;
      end
      if (na >= 0 && na <= cp && nb >= 0 && nb <= cp)
        r = '{ST_SINGLE, frac_q16(na, cp), frac_q16(nb, cp)};
    end else begin
      same = (dax * dbx + day * dby) > 0;
      if (on_segment(bsx, bsy, asx, asy, aex, aey)) begin
        if (bsx == asx && bsy == asy && !same) r = '{ST_SINGLE, '0, '0};
        else if (bsx == aex && bsy == aey && same) r = '{ST_SINGLE, T_ONE, '0};
        else r.status = ST_OVERLAP;
      end else if (on_segment(bex, bey, asx, asy, aex, aey)) begin
        if (bex == aex && bey == aey && !same) r = '{ST_SINGLE, T_ONE, T_ONE};
        else if (bex == asx && bey == asy && same) r = '{ST_SINGLE, '0, T_ONE};
        else r.status = ST_OVERLAP;
      end else if (on_segment(asx, asy, bsx, bsy, bex, bey) ||
                   on_segment(aex, aey, bsx, bsy, bex, bey)) begin
        r.status = ST_OVERLAP;
      end
    end
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] small_crd();
    return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
  endfunction

  function automatic seg_in_t random_pair();
    seg_in_t p;
    int bx, by, dx, dy, k;
    case ($urandom_range(0, 9))
      0, 1, 2: p = {$urandom, $urandom, $urandom, $urandom};
      3, 4: begin
        p.a_start_x = small_crd(); p.a_start_y = small_crd();
        p.a_end_x = small_crd();   p.a_end_y = small_crd();
        p.b_start_x = small_crd(); p.b_start_y = small_crd();
        p.b_end_x = small_crd();   p.b_end_y = small_crd();
      end
      default: begin
        // collinear: all four points on one line through a base point
        bx = int'($urandom_range(0, 2000)) - 1000;
        by = int'($urandom_range(0, 2000)) - 1000;
        dx = int'($urandom_range(0, 200)) - 100;
        dy = int'($urandom_range(0, 200)) - 100;
        k = int'($urandom_range(0, 6)) - 3;
        p.a_start_x = COORD_BITS'(bx + dx * k); p.a_start_y = COORD_BITS'(by + dy * k);
        k = int'($urandom_range(0, 6)) - 3;
        p.a_end_x = COORD_BITS'(bx + dx * k);   p.a_end_y = COORD_BITS'(by + dy * k);
        k = int'($urandom_range(0, 6)) - 3;
        p.b_start_x = COORD_BITS'(bx + dx * k); p.b_start_y = COORD_BITS'(by + dy * k);
        k = int'($urandom_range(0, 6)) - 3;
        p.b_end_x = COORD_BITS'(bx + dx * k);   p.b_end_y = COORD_BITS'(by + dy * k);
      end
    endcase
    return p;
  endfunction

  task automatic send_pair(seg_in_t p, bit typed, seg_out_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    hit_q.insert(hit_q.size(), typed ? r : predict_hit(p));
  endtask

  dir_row_t dir_rows[22];

  function automatic seg_in_t sp(int a, int b, int c, int d, int e, int f, int g, int h);
    return {COORD_BITS'(a), COORD_BITS'(b), COORD_BITS'(c), COORD_BITS'(d),
            COORD_BITS'(e), COORD_BITS'(f), COORD_BITS'(g), COORD_BITS'(h)};
  endfunction

  initial begin
    seg_out_t nohit;
    nohit = '{ST_NONE, '0, '0};
    dir_rows = '{
      '{sp(0, 0, 0, 0, 0, 0, 0, 0), 1, '{ST_SINGLE, '0, '0}},
      '{sp(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1,
        '{ST_SINGLE, '0, '0}},
      '{sp(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 1,
        '{ST_SINGLE, '0, '0}},
      '{sp(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 1,
        '{ST_SINGLE, 17'd32768, 17'd32768}},
      '{sp(0, 0, 10, 0, 0, 5, 10, 5), 1, nohit},
      '{sp(0, 0, 10, 0, 0, 0, -5, 0), 1, '{ST_SINGLE, '0, '0}},
      '{sp(0, 0, 10, 0, 10, 0, 20, 0), 1, '{ST_SINGLE, T_ONE, '0}},
      '{sp(0, 0, 10, 0, 20, 0, 10, 0), 1, '{ST_SINGLE, T_ONE, T_ONE}},
      '{sp(0, 0, 10, 0, -5, 0, 0, 0), 1, '{ST_SINGLE, '0, T_ONE}},
      '{sp(0, 0, 10, 0, 2, 0, 5, 0), 1, '{ST_OVERLAP, '0, '0}},
      '{sp(0, 0, 10, 0, -5, 0, 20, 0), 1, '{ST_OVERLAP, '0, '0}},
      '{sp(0, 0, 10, 0, 20, 0, 30, 0), 1, nohit},
      '{sp(0, 0, 10, 0, 5, 0, 5, 0), 1, '{ST_OVERLAP, '0, '0}},
      '{sp(0, 0, 10, 0, 10, 0, 0, 0), 1, '{ST_OVERLAP, '0, '0}},
      '{sp(0, 0, 10, 0, 5, 0, 5, 5), 0, nohit},
      '{sp(0, 0, 10, 0, 10, -3, 10, 7), 0, nohit},
      '{sp(0, 0, 3, 7, 0, 5, 9, -1), 0, nohit},
      '{sp(0, 0, 3, 7, 0, 5, 1, 5), 0, nohit},
      '{sp(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768), 0, nohit},
      '{sp(-32768, 0, 32767, 1, 0, -32768, 1, 32767), 0, nohit},
      '{sp(1, 1, 1, 1, 0, 0, 2, 2), 0, nohit},
      '{sp(-1, -1, 1, 1, 1, 1, 1, 1), 0, nohit}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send_pair(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].r);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        in_valid_i <= 1'b0;
        while (hit_q.size() != 0) @(posedge clk_i);
      end
      if (n == N_RANDOM - 200) quiet = 1'b1;
      send_pair(random_pair(), 1'b0, nohit);
    end
    in_valid_i <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // receiver stall bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    seg_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, out_data_o);
        errors++;
      end else begin
        want = hit_q.pop_front();
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data_o.status);
          errors++;
        end
        if (out_data_o.time_a !== want.time_a) begin
          $display("%0t: time_a expected %0d actual %0d", $time, want.time_a,
                   out_data_o.time_a);
          errors++;
        end
        if (out_data_o.time_b !== want.time_b) begin
          $display("%0t: time_b expected %0d actual %0d", $time, want.time_b,
                   out_data_o.time_b);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

### segment_intersection.f
hdl/segx_pkg.sv
hdl/segx_div.sv
hdl/segx_geom.sv
hdl/segment_intersection.sv
hdl/segx_check.sv
tb/segment_intersection_tb.sv
